/* sv/dfir_pkg.sv */
// Shared types and constants for the decimating FIR filter.
`timescale 1ns / 1ps

package dfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 6;
  localparam int DEC_W      = 5;
  localparam int TAPS_CFG_W = 7;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PROD_W     = SAMPLE_W + COEF_W;

  localparam logic [DEC_W-1:0] DEC_MAX = DEC_W'(16);

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIMATION  = 2'd0,
    REG_TAPS_IN_USE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                         mode;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         block_start;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0]     coef_value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } result_t;

  typedef struct packed {
    logic clear;
    logic tap_vld;
    logic tap_last;
  } mac_ctrl_t;

endpackage

/* sv/dfir_dly.sv */
// Circular delay line memory with head pointer and fill count.
`timescale 1ns / 1ps

module dfir_dly import dfir_pkg::*; #(
  parameter int TAPS = 64,
  parameter int AW   = 6,
  parameter int CW   = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_tap,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic [AW-1:0]              head;
  logic [AW-1:0]              head_next;
  logic [CW-1:0]              fill;
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rd_live;

  assign head_next = (head == AW'(TAPS - 1)) ? '0 : head + AW'(1);
  assign rd_addr   = (head >= rd_tap) ? head - rd_tap : head + AW'(TAPS) - rd_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (wr_en) begin
      head <= head_next;
      if (fill != CW'(TAPS)) begin
        fill <= fill + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_next] <= wr_data;
    end
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_live <= CW'(rd_tap) < fill;
    end
  end

  assign rd_data = rd_live ? rd_q : '0;

endmodule

/* sv/dfir_coef.sv */
// Coefficient memory with per-entry valid bits.
`timescale 1ns / 1ps

module dfir_coef import dfir_pkg::*; #(
  parameter int TAPS = 64,
  parameter int AW   = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [COEF_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [COEF_W-1:0] rd_data
);

  logic signed [COEF_W-1:0] mem [TAPS];
  logic [TAPS-1:0]          vld;
  logic signed [COEF_W-1:0] rd_q;
  logic                     rd_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_live <= vld[rd_addr];
    end
  end

  assign rd_data = rd_live ? rd_q : '0;

endmodule

/* sv/dfir_mac.sv */
// Shared multiply-accumulate with scaling and 16-bit saturation.
`timescale 1ns / 1ps

module dfir_mac import dfir_pkg::*; #(
  parameter int ACC_W     = 38,
  parameter int COEF_FRAC = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] smp,
  input  logic signed [COEF_W-1:0]   coef,
  output logic                       done,
  output result_t                    res
);

  localparam longint ROUND_L = (longint'(1) << COEF_FRAC) - 1;
  localparam longint HI_L    = longint'(32767) << COEF_FRAC;
  localparam longint LO_L    = -(longint'(32768) << COEF_FRAC);

  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(ROUND_L);
  localparam logic signed [ACC_W-1:0] HI    = ACC_W'(HI_L);
  localparam logic signed [ACC_W-1:0] LO    = ACC_W'(LO_L);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_last;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.tap_vld) begin
      prod <= smp * coef;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld  <= 1'b0;
      prod_last <= 1'b0;
      acc_last  <= 1'b0;
      done      <= 1'b0;
    end else begin
      prod_vld  <= ctrl.tap_vld;
      prod_last <= ctrl.tap_vld && ctrl.tap_last;
      acc_last  <= prod_vld && prod_last;
      done      <= acc_last;
    end
  end

  assign biased  = acc + (acc[ACC_W-1] ? ROUND : '0);
  assign shifted = biased >>> COEF_FRAC;

  always_ff @(posedge clk) begin
    if (acc_last) begin
      if (acc > HI) begin
        res.filtered <= 16'sh7fff;
        res.clipped  <= 1'b1;
      end else if (acc < LO) begin
        res.filtered <= -16'sh8000;
        res.clipped  <= 1'b1;
      end else begin
        res.filtered <= shifted[SAMPLE_W-1:0];
        res.clipped  <= 1'b0;
      end
    end
  end

endmodule

/* sv/decimating_fir_filter.sv */
// Decimating FIR filter top level: control sequencer, config and result register.
`timescale 1ns / 1ps

// Direct-form FIR over signed 16-bit samples with decimation. A coefficient
// beat, and a sample beat that falls off the decimation phase, are taken in the
// idle state without leaving it. A kept sample is taken in the idle state, then
// one shared multiplier walks the taps one per cycle, reading one entry of the
// delay-line memory and one of the coefficient memory each cycle, then the
// pipeline drains through the memory read, product, accumulator and saturation
// registers, then the result register is loaded, which stretches while an
// earlier result is still unaccepted. The result register decouples the output
// side, so the next beat is taken while a result waits.
// Both memories read as zero until written; no clearing pass follows reset.
module decimating_fir_filter import dfir_pkg::*; #(
  parameter int TAPS      = 64,
  parameter int COEF_FRAC = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(TAPS);
  localparam int CW    = $clog2(TAPS + 1);
  localparam int ACC_W = PROD_W + $clog2(TAPS);

  state_t               state;
  state_t               state_next;
  logic [DEC_W-1:0]     decimation;
  logic [TAPS_CFG_W-1:0] taps_in_use;
  logic [PHASE_W-1:0]   phase;
  logic [AW-1:0]        tap;
  logic [AW-1:0]        last_tap;
  logic                 rd_vld;
  logic                 rd_last;

  logic                 take;
  logic                 smp_go;
  logic                 coef_go;
  logic                 launch;
  logic                 rd_en;
  logic                 rd_end;
  logic                 load;
  logic [PHASE_W-1:0]   ph_start;
  logic [DEC_W-1:0]     ph_inc;
  logic [DEC_W-1:0]     dec_eff;
  logic [8:0]           tap_lim;
  logic signed [SAMPLE_W-1:0] dly_q;
  logic signed [COEF_W-1:0]   coef_q;
  mac_ctrl_t            mac_ctrl;
  logic                 mac_done;
  result_t              mac_res;

  assign cfg_ready = 1'b1;
  assign take      = item_valid && item_ready;
  assign smp_go    = take && (item.mode == MODE_FILTER);
  assign coef_go   = take && (item.mode == MODE_COEF) && (9'(item.coef_index) < 9'(TAPS));

  assign ph_start = item.block_start ? '0 : phase;
  assign ph_inc   = {1'b0, ph_start} + DEC_W'(1);
  always_comb begin
    priority if (decimation == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation > DEC_MAX) begin
      dec_eff = DEC_MAX;
    end else begin
      dec_eff = decimation;
    end
  end
  assign launch = smp_go && (ph_start == '0);

  always_comb begin
    priority if (taps_in_use == '0) begin
      tap_lim = 9'd1;
    end else if (9'(taps_in_use) > 9'(TAPS)) begin
      tap_lim = 9'(TAPS);
    end else begin
      tap_lim = 9'(taps_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation  <= DEC_W'(1);
      taps_in_use <= TAPS_CFG_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECIMATION:  decimation  <= cfg_data[DEC_W-1:0];
        REG_TAPS_IN_USE: taps_in_use <= cfg_data[TAPS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (smp_go) begin
      phase <= (ph_inc >= dec_eff) ? '0 : ph_inc[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    rd_end     = tap == last_tap;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (launch) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (rd_end) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      tap      <= '0;
      last_tap <= AW'(tap_lim - 9'd1);
    end else if (rd_en) begin
      tap <= tap + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_vld  <= rd_en;
      rd_last <= rd_en && rd_end;
    end
  end

  assign mac_ctrl.clear    = launch;
  assign mac_ctrl.tap_vld  = rd_vld;
  assign mac_ctrl.tap_last = rd_last;

  dfir_dly #(
    .TAPS (TAPS),
    .AW   (AW),
    .CW   (CW)
  ) u_dly (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (smp_go),
    .wr_data (item.sample),
    .rd_en   (rd_en),
    .rd_tap  (tap),
    .rd_data (dly_q)
  );

  dfir_coef #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_coef (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (coef_go),
    .wr_addr (AW'(item.coef_index)),
    .wr_data (item.coef_value),
    .rd_en   (rd_en),
    .rd_addr (tap),
    .rd_data (coef_q)
  );

  dfir_mac #(
    .ACC_W     (ACC_W),
    .COEF_FRAC (COEF_FRAC)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .smp  (dly_q),
    .coef (coef_q),
    .done (mac_done),
    .res  (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= mac_res;
    end
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("accumulator finished outside the wait state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FINISH)
    else $error("result beat raised outside the finish state");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == ST_IDLE || state == ST_READ)
    else $error("accepted beat left the sequencer in a wrong state");
`endif

endmodule
